@@ rtl/ccc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants for the concept closure check block.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int MAX_OBJECTS    = 1024;
	localparam int ATTRIBUTE_BITS = 25;
	localparam int IDX_W          = $clog2(MAX_OBJECTS);
	localparam int CNT_W          = $clog2(MAX_OBJECTS + 1);
	localparam int CFG_W          = (ATTRIBUTE_BITS > CNT_W) ? ATTRIBUTE_BITS : CNT_W;

	typedef logic [ATTRIBUTE_BITS-1:0] attr_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		REG_OBJECT_COUNT   = 1'b0,
		REG_ATTRIBUTE_MASK = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t   op;
		idx_t  object_index;
		attr_t object_row;
		attr_t candidate;
	} item_t;

	typedef struct packed {
		logic  is_concept;
		attr_t closure;
		cnt_t  support_count;
	} result_t;

	localparam cnt_t  MAX_ROWS  = CNT_W'(MAX_OBJECTS);
	localparam attr_t FULL_ATTR = '1;

endpackage
`default_nettype wire

@@ rtl/ccc_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_store
// Object row memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ccc_store (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire ccc_pkg::idx_t  wr_addr,
	input  wire ccc_pkg::attr_t wr_data,
	input  wire logic          rd_en,
	input  wire ccc_pkg::idx_t  rd_addr,
	output ccc_pkg::attr_t      rd_data
);
	import ccc_pkg::*;

	attr_t rows_mem [MAX_OBJECTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= rows_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/concept_closure_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// concept_closure_check
// Load transactions write one object row. A query walks rows
// 0 .. min(object_count, 1024)-1, one memory read per cycle through a shared
// AND/compare/count unit; a drain state follows, then the finish state (entered
// straight from idle with no rows in use) registers the result once an earlier
// result has been accepted, and the next item can be taken as it becomes valid.
// Async active-low reset clears control and config; row memory is not cleared.
// ----------------------------------------------------------------------------
module concept_closure_check (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire ccc_pkg::reg_idx_t  cfg_index,
	input  wire logic [ccc_pkg::CFG_W-1:0] cfg_data,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire ccc_pkg::item_t     item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output ccc_pkg::result_t        result
);
	import ccc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t  state_q;
	cnt_t    obj_count_q;
	attr_t   attr_mask_q;
	attr_t   cand_q;
	attr_t   acc_q;
	cnt_t    sup_q;
	cnt_t    addr_q;
	cnt_t    rows_q;
	logic    rd_v_s1;
	attr_t   rd_data;
	logic    rd_en;
	logic    item_acc;
	logic    out_free;
	cnt_t    rows_sat;
	cnt_t    addr_nxt;

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign out_free   = !result_valid || result_ready;
	assign rd_en      = (state_q == ST_WALK);
	assign addr_nxt   = addr_q + cnt_t'(1);
	assign rows_sat   = (obj_count_q > MAX_ROWS) ? MAX_ROWS : obj_count_q;

	ccc_store u_store (
		.clk     (clk),
		.wr_en   (item_acc && (item.op == OP_LOAD)),
		.wr_addr (item.object_index),
		.wr_data (item.object_row),
		.rd_en   (rd_en),
		.rd_addr (addr_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_count_q <= '0;
			attr_mask_q <= FULL_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OBJECT_COUNT:   obj_count_q <= cfg_data[CNT_W-1:0];
				REG_ATTRIBUTE_MASK: attr_mask_q <= cfg_data[ATTRIBUTE_BITS-1:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.op == OP_QUERY)) begin
						state_q <= (rows_sat == '0) ? ST_FINISH : ST_WALK;
					end
				end
				ST_WALK: begin
					if (addr_nxt == rows_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && (item.op == OP_QUERY)) begin
			cand_q <= item.candidate;
			acc_q  <= attr_mask_q;
			sup_q  <= '0;
			addr_q <= '0;
			rows_q <= rows_sat;
		end else begin
			if (rd_en) begin
				addr_q <= addr_nxt;
			end
			if (rd_v_s1 && ((rd_data & cand_q) == cand_q)) begin
				acc_q <= acc_q & rd_data;
				sup_q <= sup_q + cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			result.is_concept    <= (acc_q == cand_q) && (sup_q != '0);
			result.closure       <= acc_q;
			result.support_count <= sup_q;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ccc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks for concept_closure_check, attached by bind.
// ----------------------------------------------------------------------------
module ccc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_ready,
	input wire ccc_pkg::item_t    item,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire ccc_pkg::result_t  result
);
	import ccc_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result transaction changed while stalled");

	a_concept_support: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_concept |-> result.support_count != '0)
		else $error("concept flagged without support");

	a_support_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.support_count <= MAX_ROWS)
		else $error("support count above row limit");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.op == OP_QUERY) |=> !item_ready)
		else $error("item taken while query in progress");

endmodule

bind concept_closure_check ccc_checker u_ccc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

@@ verif/concept_closure_check_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// concept_closure_check_test
// Self-checking bench for the concept closure check block. Row loads and
// candidate queries go in as transactions through a bursty driver. A local
// closure predictor keeps its own copy of the row store and registers.
// Results are checked in order against it while the result side stalls at random.
// ----------------------------------------------------------------------------
module concept_closure_check_test;
	import ccc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	reg_idx_t            cfg_index = REG_OBJECT_COUNT;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	item_t               item_bus = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result_bus;

	concept_closure_check uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	attr_t    store_copy [MAX_OBJECTS];
	cnt_t     rows_in_use = '0;
	attr_t    attr_in_use = FULL_ATTR;
	result_t  expected_results [$];

	// stimulus plan
	item_t    pending_items [$];
	attr_t    plan_rows [MAX_OBJECTS];
	bit       plan_written [MAX_OBJECTS];
	int       plan_prefix = 0;

	int       errors = 0;
	int       results_seen = 0;
	logic     item_taken = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       window_left = 0;
	int       stall_mode = 0;

	function automatic result_t closure_of(attr_t cand);
		int     walk;
		attr_t  acc;
		cnt_t   hits;
		result_t r;
		walk = (rows_in_use > MAX_ROWS) ? MAX_OBJECTS : int'(rows_in_use);
		acc = attr_in_use;
		hits = '0;
		for (int k = 0; k < walk; k++) begin
			if ((store_copy[k] & cand) == cand) begin
				acc &= store_copy[k];
				hits++;
			end
		end
		r.is_concept = (acc == cand) && (hits != 0);
		r.closure = acc;
		r.support_count = hits;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		if (errors <= 50)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	// input monitor and result checker
	always @(posedge clk) begin
		result_t want;
		item_taken <= item_valid && item_ready;
		if (arst_n && item_valid && item_ready) begin
			if (item_bus.op == OP_LOAD)
				store_copy[item_bus.object_index] = item_bus.object_row;
			else
				expected_results.push_back(closure_of(item_bus.candidate));
		end
		if (arst_n && result_valid && result_ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", longint'(result_bus),
					longint'(0));
			end else begin
				want = expected_results.pop_front();
				if (result_bus.is_concept !== want.is_concept)
					report_mismatch("is_concept", longint'(result_bus.is_concept),
						longint'(want.is_concept));
				if (result_bus.closure !== want.closure)
					report_mismatch("closure", longint'(result_bus.closure),
						longint'(want.closure));
				if (result_bus.support_count !== want.support_count)
					report_mismatch("support_count", longint'(result_bus.support_count),
						longint'(want.support_count));
			end
		end
	end

	// item driver: bursts with random gaps
	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			if (gap_left != 0) begin
				item_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() != 0) begin
				item_valid <= 1'b1;
				item_bus <= pending_items.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result side: windowed stall pattern plus one long hold
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 60) begin
			result_ready <= 1'b0;
			hold_left <= 300;
			hold_done <= 1'b1;
		end else begin
			if (window_left == 0) begin
				window_left <= $urandom_range(16, 80);
				stall_mode <= $urandom_range(0, 3);
			end else begin
				window_left <= window_left - 1;
			end
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= ($urandom_range(0, 3) != 0);
				2: result_ready <= $urandom_range(0, 1);
				default: result_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_OBJECT_COUNT)
			rows_in_use = val[CNT_W-1:0];
		else
			attr_in_use = val[ATTRIBUTE_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_count(int cnt);
		logic [CFG_W-1:0] val;
		val = ($urandom_range(0, 1) == 0) ? '0 : CFG_W'($urandom);
		val[CNT_W-1:0] = CNT_W'(cnt);
		write_reg(REG_OBJECT_COUNT, val);
	endtask

	task automatic push_load(int idx, attr_t row);
		item_t t;
		t.op = OP_LOAD;
		t.object_index = idx_t'(idx);
		t.object_row = row;
		t.candidate = attr_t'($urandom);
		pending_items.push_back(t);
		plan_rows[idx] = row;
		plan_written[idx] = 1'b1;
		while (plan_prefix < MAX_OBJECTS && plan_written[plan_prefix])
			plan_prefix++;
	endtask

	task automatic push_query(attr_t cand);
		item_t t;
		t.op = OP_QUERY;
		t.object_index = idx_t'($urandom);
		t.object_row = attr_t'($urandom);
		t.candidate = cand;
		pending_items.push_back(t);
	endtask

	function automatic attr_t make_row();
		attr_t r;
		case ($urandom_range(0, 9))
			0: r = '0;
			1: r = FULL_ATTR;
			2, 3: r = attr_t'($urandom | $urandom);
			4: r = attr_t'($urandom & $urandom);
			5, 6: begin
				if (plan_prefix > 0)
					r = plan_rows[$urandom_range(0, plan_prefix - 1)]
						^ (attr_t'(1) << $urandom_range(0, ATTRIBUTE_BITS - 1));
				else
					r = attr_t'($urandom);
			end
			default: r = attr_t'($urandom);
		endcase
		return r;
	endfunction

	function automatic attr_t make_candidate(int lim);
		attr_t pick;
		attr_t other;
		attr_t c;
		pick = (lim > 0) ? plan_rows[$urandom_range(0, lim - 1)] : attr_t'($urandom);
		other = (lim > 0) ? plan_rows[$urandom_range(0, lim - 1)] : attr_t'($urandom);
		case ($urandom_range(0, 11))
			0: c = '0;
			1: c = FULL_ATTR;
			2: c = attr_t'($urandom);
			3, 4: c = pick;
			5, 6, 7: c = pick & attr_t'($urandom);
			8: c = pick & attr_t'($urandom) & attr_t'($urandom);
			9: c = pick & other;
			10: c = attr_t'(1) << $urandom_range(0, ATTRIBUTE_BITS - 1);
			default: c = pick & other & attr_t'($urandom);
		endcase
		return c;
	endfunction

	task automatic drain();
		while (!(pending_items.size() == 0 && !item_valid && expected_results.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(int cnt, attr_t amask, int n_items);
		int lim;
		set_count(cnt);
		write_reg(REG_ATTRIBUTE_MASK, CFG_W'(amask));
		lim = (cnt > MAX_OBJECTS) ? MAX_OBJECTS : cnt;
		for (int k = plan_prefix; k < lim; k++)
			push_load(k, make_row());
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 99) < 35) begin
				if ($urandom_range(0, 1) == 0)
					push_load($urandom_range(0, MAX_OBJECTS - 1), make_row());
				else
					push_load($urandom_range(0, lim + 3 < MAX_OBJECTS ? lim + 3 : lim - 1),
						make_row());
			end else begin
				push_query(make_candidate(lim));
			end
		end
		drain();
	endtask

	initial begin
		int cnt;
		attr_t amask;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// no rows in use: nothing supports, full candidate is not a concept
		push_query(FULL_ATTR);
		push_query('0);
		drain();

		set_count(5);
		write_reg(REG_ATTRIBUTE_MASK, CFG_W'(FULL_ATTR));
		push_load(0, '0);
		push_load(1, FULL_ATTR);
		push_load(2, 25'h1555555);
		push_load(3, 25'h0AAAAAA);
		push_load(4, 25'h1555554);
		push_load(MAX_OBJECTS - 1, FULL_ATTR);
		push_query('0);
		push_query(FULL_ATTR);
		push_query(25'h1555555);
		push_query(25'h0AAAAAA);
		push_query(25'h0000001);
		drain();

		// candidate reaching outside the attribute mask
		write_reg(REG_ATTRIBUTE_MASK, CFG_W'(25'h0FFFFFF));
		push_query(FULL_ATTR);
		push_query(25'h0AAAAAA);
		drain();

		write_reg(REG_ATTRIBUTE_MASK, '0);
		push_query('0);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p == 0)
				cnt = 1;
			else if (p == 3)
				cnt = 0;
			else if (p == 7)
				cnt = 200;
			else
				cnt = $urandom_range(2, 48);
			if (p % 4 == 1)
				amask = attr_t'($urandom);
			else if (p == 5)
				amask = '0;
			else if (p == 10)
				amask = attr_t'($urandom) & attr_t'($urandom);
			else
				amask = FULL_ATTR;
			run_phase(cnt, amask, 46);
		end

		// whole store, then counts past the store size
		run_phase(MAX_OBJECTS, FULL_ATTR, 6);
		run_phase(2047, attr_t'($urandom | $urandom), 4);
		run_phase(MAX_OBJECTS + 1, FULL_ATTR, 3);

		if (errors == 0)
			$display("concept_closure_check_test passed");
		else
			$display("concept_closure_check_test failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("concept_closure_check_test failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/ccc_pkg.sv
rtl/ccc_store.sv
rtl/concept_closure_check.sv
rtl/ccc_checker.sv
verif/concept_closure_check_test.sv
